FILE: src/jtdk_pkg.sv
// ----------------------------------------------------------------------------
// jtdk_pkg
// Shared types and constants for the joystick to direction key converter.
// ----------------------------------------------------------------------------
package jtdk_pkg;

    // sample and register widths
    localparam int SAMPLE_BITS = 10;
    localparam int MAG_W       = 10;
    localparam int DIAG_W      = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int EV_MAX      = 4;
    localparam int CNT_W       = 3;

    // register reset values
    localparam logic [9:0]        CENTER_X_RST = 10'd783;
    localparam logic [9:0]        CENTER_Y_RST = 10'd748;
    localparam logic [MAG_W-1:0]  BASE_DZ_RST  = 10'd100;
    localparam logic [DIAG_W-1:0] DIAG_DZ_RST  = 11'd200;

    // direction key codes
    typedef enum logic [1:0] {
        KEY_UP    = 2'd0,
        KEY_DOWN  = 2'd1,
        KEY_LEFT  = 2'd2,
        KEY_RIGHT = 2'd3
    } t_key;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_BASE_DZ     = 3'd2,
        CFG_DIAG_DZ     = 3'd3,
        CFG_INVERT_X    = 3'd4,
        CFG_INVERT_Y    = 3'd5,
        CFG_MODE_ENABLE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]        center_x;
        logic [9:0]        center_y;
        logic [MAG_W-1:0]  base_dz;
        logic [DIAG_W-1:0] diag_dz;
        logic              invert_x;
        logic              invert_y;
        logic              mode_enable;
    } t_cfg;

    // one classified axis: nz is set when the offset survives the deadzone
    typedef struct packed {
        logic              nz;
        logic              neg;
        logic [MAG_W-1:0]  mag;
    } t_axis;

    typedef struct packed {
        t_key key;
        logic is_press;
    } t_event;

    // all events caused by one sample, slot 0 first
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        t_event [EV_MAX-1:0]     events;
    } t_batch;

endpackage

FILE: src/jtdk_front.sv
// ----------------------------------------------------------------------------
// jtdk_front
// Takes samples, forms deadzoned offsets, then classifies them against the
// held key flags and hands the resulting event batch to the queue.
// ----------------------------------------------------------------------------
module jtdk_front import jtdk_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_x,
    input  logic [SAMPLE_BITS-1:0] i_sample_y,
    output logic                   o_push,
    output t_batch                 o_batch,
    input  logic                   i_q_ready
);

    // offset magnitude, sign and deadzone test for one axis
    function automatic t_axis axis_of(input logic [SAMPLE_BITS-1:0] s,
                                      input logic [9:0]             c,
                                      input logic                   inv,
                                      input logic [MAG_W-1:0]       base);
        t_axis a;
        logic  ge;
        ge    = (s >= c);
        a.mag = ge ? (s - c) : (c - s);
        a.neg = inv ? (s > c) : !ge;
        a.nz  = (a.mag != '0) && !(a.mag < base);
        return a;
    endfunction

    logic              r_s1_valid;
    t_axis             r_x;
    t_axis             r_y;
    logic [3:0]        r_held;
    logic [3:0]        n_held;

    logic              adv;
    logic              need;
    logic              vert;
    logic [MAG_W-1:0]  ex;
    logic [MAG_W-1:0]  ey;
    t_axis             dom;
    t_axis             mnr;
    t_key              dom_pos;
    t_key              dom_neg;
    t_key              min_pos;
    t_key              min_neg;
    t_key              press_k;
    t_key              rel_k;
    t_key              min_k;
    logic              beyond;
    logic [CNT_W-1:0]  cnt;
    t_event [EV_MAX-1:0] ev;

    // stage 1: offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_x <= axis_of(i_sample_x, i_cfg.center_x, i_cfg.invert_x, i_cfg.base_dz);
            r_y <= axis_of(i_sample_y, i_cfg.center_y, i_cfg.invert_y, i_cfg.base_dz);
        end
    end

    // stage 2: dominance and minor-axis selection
    always_comb begin
        ex   = r_x.nz ? r_x.mag : '0;
        ey   = r_y.nz ? r_y.mag : '0;
        vert = (ey >= ex);
        if (vert) begin
            dom     = r_y;
            mnr     = r_x;
            dom_pos = KEY_DOWN;
            dom_neg = KEY_UP;
            min_pos = KEY_RIGHT;
            min_neg = KEY_LEFT;
        end else begin
            dom     = r_x;
            mnr     = r_y;
            dom_pos = KEY_RIGHT;
            dom_neg = KEY_LEFT;
            min_pos = KEY_DOWN;
            min_neg = KEY_UP;
        end
        press_k = dom.neg ? dom_neg : dom_pos;
        rel_k   = dom.neg ? dom_pos : dom_neg;
        min_k   = mnr.neg ? min_neg : min_pos;
        beyond  = ({1'b0, mnr.mag} > i_cfg.diag_dz);
    end

    // stage 2: event list and next held flags
    always_comb begin
        n_held = r_held;
        cnt    = '0;
        ev     = '0;
        if (r_s1_valid && i_cfg.mode_enable) begin
            if (!r_x.nz && !r_y.nz) begin
                // neutral: release everything in fixed order
                ev[0]  = '{key: KEY_UP,    is_press: 1'b0};
                ev[1]  = '{key: KEY_DOWN,  is_press: 1'b0};
                ev[2]  = '{key: KEY_LEFT,  is_press: 1'b0};
                ev[3]  = '{key: KEY_RIGHT, is_press: 1'b0};
                cnt    = 3'd4;
                n_held = '0;
            end else begin
                if (!n_held[press_k]) begin
                    ev[cnt[1:0]]    = '{key: press_k, is_press: 1'b1};
                    cnt             = cnt + 3'd1;
                    n_held[press_k] = 1'b1;
                end
                if (n_held[rel_k]) begin
                    ev[cnt[1:0]]  = '{key: rel_k, is_press: 1'b0};
                    cnt           = cnt + 3'd1;
                    n_held[rel_k] = 1'b0;
                end
                if (mnr.nz) begin
                    if (beyond && !n_held[min_k]) begin
                        ev[cnt[1:0]]  = '{key: min_k, is_press: 1'b1};
                        cnt           = cnt + 3'd1;
                        n_held[min_k] = 1'b1;
                    end else if (!beyond && n_held[min_k]) begin
                        ev[cnt[1:0]]  = '{key: min_k, is_press: 1'b0};
                        cnt           = cnt + 3'd1;
                        n_held[min_k] = 1'b0;
                    end
                end
            end
        end
    end

    // handshake toward the queue; empty batches retire without a slot
    assign need    = (cnt != '0);
    assign adv     = r_s1_valid && (!need || i_q_ready);
    assign o_push  = r_s1_valid && need && i_q_ready;
    assign o_batch = '{count: cnt, events: ev};
    assign o_ready = !r_s1_valid || adv;

    // held key flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (adv) begin
            r_held <= n_held;
        end
    end

endmodule

FILE: src/jtdk_queue.sv
// ----------------------------------------------------------------------------
// jtdk_queue
// Two-entry FIFO of event batches between the classifier and the serializer.
// ----------------------------------------------------------------------------
module jtdk_queue import jtdk_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_batch i_data,
    output logic   o_ready,
    output logic   o_valid,
    output t_batch o_data,
    input  logic   i_pop
);

    t_batch     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/jtdk_back.sv
// ----------------------------------------------------------------------------
// jtdk_back
// Serializes the head batch into single key events, one per cycle while the
// master port accepts them, through a registered output stage.
// ----------------------------------------------------------------------------
module jtdk_back import jtdk_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_batch i_batch,
    output logic   o_pop,
    output logic   o_tvalid,
    input  logic   i_tready,
    output t_key   o_key,
    output logic   o_is_press,
    output logic   o_last
);

    logic       r_out_valid;
    t_key       r_key;
    logic       r_press;
    logic       r_last;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       load;
    logic       is_last;
    t_event     cur;

    // output slot is free when empty or being taken
    assign load    = !r_out_valid || i_tready;
    assign cur     = i_batch.events[r_idx];
    assign is_last = ({1'b0, r_idx} == (i_batch.count - 3'd1));
    assign o_pop   = load && i_valid && is_last;
    assign n_idx   = is_last ? 2'd0 : (r_idx + 2'd1);

    // event index within the head batch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                r_idx <= n_idx;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_key   <= cur.key;
            r_press <= cur.is_press;
            r_last  <= is_last;
        end
    end

    assign o_tvalid   = r_out_valid;
    assign o_key      = r_key;
    assign o_is_press = r_press;
    assign o_last     = r_last;

endmodule

FILE: src/joystick_to_direction_keys_top.sv
// ----------------------------------------------------------------------------
// joystick_to_direction_keys_top
// Turns analog stick samples into press/release events for four direction keys.
// ----------------------------------------------------------------------------
// A sample pair is accepted whenever the offset stage is empty or its batch
// can leave it, which for a non-empty batch needs room in the two-entry event
// queue; it produces zero to four key events, which leave the master port one
// per cycle while it is ready (four for a neutral stick, at most three
// otherwise). The output serializer sets the sustained rate. A sample's first
// event passes the offset register, the event queue and the output register,
// in that order, before it is valid on the master port. Samples taken while
// mode_enable is low produce nothing. Registers are written through the cfg
// channel, which is always ready.
module joystick_to_direction_keys_top import jtdk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample input
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,  // [9:0] sample_x, [19:10] sample_y
    // key event output
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,  // [1:0] key_id, [2] is_press
    output logic                  o_m_axis_tlast   // last_event
);

    t_cfg   r_cfg;
    logic   q_push;
    logic   q_ready;
    logic   q_valid;
    logic   q_pop;
    t_batch front_batch;
    t_batch q_batch;
    t_key   out_key;
    logic   out_press;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= CENTER_X_RST;
            r_cfg.center_y    <= CENTER_Y_RST;
            r_cfg.base_dz     <= BASE_DZ_RST;
            r_cfg.diag_dz     <= DIAG_DZ_RST;
            r_cfg.invert_x    <= 1'b0;
            r_cfg.invert_y    <= 1'b1;
            r_cfg.mode_enable <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_data[9:0];
                CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data[9:0];
                CFG_BASE_DZ:     r_cfg.base_dz     <= i_cfg_data[MAG_W-1:0];
                CFG_DIAG_DZ:     r_cfg.diag_dz     <= i_cfg_data[DIAG_W-1:0];
                CFG_INVERT_X:    r_cfg.invert_x    <= i_cfg_data[0];
                CFG_INVERT_Y:    r_cfg.invert_y    <= i_cfg_data[0];
                CFG_MODE_ENABLE: r_cfg.mode_enable <= i_cfg_data[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // classifier
    jtdk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_sample_x (i_s_axis_tdata[9:0]),
        .i_sample_y (i_s_axis_tdata[19:10]),
        .o_push     (q_push),
        .o_batch    (front_batch),
        .i_q_ready  (q_ready)
    );

    // batch queue
    jtdk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_batch),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_batch),
        .i_pop   (q_pop)
    );

    // event serializer
    jtdk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_batch    (q_batch),
        .o_pop      (q_pop),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_key      (out_key),
        .o_is_press (out_press),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'd0, out_press, out_key};

    // batches only come from an enabled block
    a_push_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> r_cfg.mode_enable)
        else $error("event batch queued while mode disabled");

    // every queued batch carries one to four events
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (front_batch.count != 3'd0) && (front_batch.count <= 3'd4))
        else $error("queued batch has bad event count");

    // a four-event batch is the neutral release sweep
    a_four_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && (front_batch.count == 3'd4)) |->
            (!front_batch.events[0].is_press && !front_batch.events[1].is_press &&
             !front_batch.events[2].is_press && !front_batch.events[3].is_press))
        else $error("four-event batch contains a press");

    // rest of a batch follows right after a non-final event is taken
    a_batch_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> o_m_axis_tvalid)
        else $error("gap inside an event batch");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for joystick_to_direction_keys_top. Stick samples go in
// on the slave stream and key events come back on the master stream. A
// scoreboard predicts the press/release events of every accepted sample from
// its own copy of the registers and the held-key flags. Directed samples cover
// the corner cases; random samples run under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import jtdk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 1000;  // cycles with no transaction at all
    localparam int SETTLE_CYC  = 10;    // covers the pipeline from input to output
    localparam int PHASE_ITEMS = 48;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        t_key key;
        logic press;
        logic last;
    } t_key_event;

    // ------------------------------------------------------------------------
    // Key event scoreboard: tracks registers and held keys, queues events
    // ------------------------------------------------------------------------
    class key_event_scoreboard;
        logic [9:0]  cx, cy, base_dz;
        logic [10:0] diag_dz;
        bit          inv_x, inv_y, enable;
        bit          held[4];
        t_key_event  expected_events[$];
        t_key_event  step_events[$];
        int          errors;

        function new();
            cx      = CENTER_X_RST;
            cy      = CENTER_Y_RST;
            base_dz = BASE_DZ_RST;
            diag_dz = DIAG_DZ_RST;
            inv_x   = 1'b0;
            inv_y   = 1'b1;
            enable  = 1'b1;
            foreach (held[k]) held[k] = 1'b0;
            errors  = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, int val);
            case (idx)
                CFG_CENTER_X:    cx      = val[9:0];
                CFG_CENTER_Y:    cy      = val[9:0];
                CFG_BASE_DZ:     base_dz = val[9:0];
                CFG_DIAG_DZ:     diag_dz = val[10:0];
                CFG_INVERT_X:    inv_x   = val[0];
                CFG_INVERT_Y:    inv_y   = val[0];
                CFG_MODE_ENABLE: enable  = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function int mag(int v);
            return (v < 0) ? -v : v;
        endfunction

        // signed offset from center, zeroed inside the base deadzone
        function int axis_offset(logic [9:0] raw, logic [9:0] center, bit inv);
            int r, c, d;
            r = raw;
            c = center;
            d = inv ? (c - r) : (r - c);
            if (mag(d) < int'(base_dz)) d = 0;
            return d;
        endfunction

        function void add_event(t_key key, logic press);
            t_key_event e;
            e.key   = key;
            e.press = press;
            e.last  = 1'b0;
            step_events.push_back(e);
        endfunction

        // dominant axis: press own side, release the opposite side
        function void drive_major(int d, t_key pos_key, t_key neg_key);
            t_key on_key, off_key;
            on_key  = (d > 0) ? pos_key : neg_key;
            off_key = (d > 0) ? neg_key : pos_key;
            if (!held[on_key]) begin
                add_event(on_key, 1'b1);
                held[on_key] = 1'b1;
            end
            if (held[off_key]) begin
                add_event(off_key, 1'b0);
                held[off_key] = 1'b0;
            end
        endfunction

        // minor axis: only the key on the offset's side is touched
        function void drive_minor(int d, t_key pos_key, t_key neg_key);
            t_key k;
            bit   beyond;
            if (d == 0) return;
            beyond = mag(d) > int'(diag_dz);
            k = (d > 0) ? pos_key : neg_key;
            if (beyond && !held[k]) begin
                add_event(k, 1'b1);
                held[k] = 1'b1;
            end else if (!beyond && held[k]) begin
                add_event(k, 1'b0);
                held[k] = 1'b0;
            end
        endfunction

        function void note_sample(logic [9:0] sx, logic [9:0] sy);
            int         dx, dy;
            t_key_event e;
            step_events.delete();
            if (!enable) return;
            dx = axis_offset(sx, cx, inv_x);
            dy = axis_offset(sy, cy, inv_y);
            if (dx == 0 && dy == 0) begin
                add_event(KEY_UP, 1'b0);
                add_event(KEY_DOWN, 1'b0);
                add_event(KEY_LEFT, 1'b0);
                add_event(KEY_RIGHT, 1'b0);
                foreach (held[k]) held[k] = 1'b0;
            end else if (mag(dy) >= mag(dx)) begin
                drive_major(dy, KEY_DOWN, KEY_UP);
                drive_minor(dx, KEY_RIGHT, KEY_LEFT);
            end else begin
                drive_major(dx, KEY_RIGHT, KEY_LEFT);
                drive_minor(dy, KEY_DOWN, KEY_UP);
            end
            foreach (step_events[i]) begin
                e = step_events[i];
                e.last = (i == step_events.size() - 1);
                expected_events.push_back(e);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_event(logic [1:0] key, logic press, logic last);
            t_key_event e;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event key=%0d press=%0b last=%0b",
                                 key, press, last));
                return;
            end
            e = expected_events.pop_front();
            if (key !== e.key)
                report($sformatf("key_id got %0d want %0d", key, e.key));
            if (press !== e.press)
                report($sformatf("is_press got %0b want %0b (key %0d)",
                                 press, e.press, e.key));
            if (last !== e.last)
                report($sformatf("last_event got %0b want %0b (key %0d)",
                                 last, e.last, e.key));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and clock
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata = '0;   // [9:0] sample_x, [19:10] sample_y
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [7:0]            o_m_axis_tdata;        // [1:0] key_id, [2] is_press
    logic                  o_m_axis_tlast;        // last_event

    key_event_scoreboard sb;
    bit                  no_idle = 1'b0;
    int                  idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    joystick_to_direction_keys_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after too long without any transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[joystick_to_direction_keys_top] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event receiver: random stalls, checks each accepted transaction
    // ------------------------------------------------------------------------
    initial begin : event_sink
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            sb.check_event(o_m_axis_tdata[1:0], o_m_axis_tdata[2], o_m_axis_tlast);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each starts and ends at a falling edge
    // ------------------------------------------------------------------------
    task send_sample(input logic [9:0] sx, input logic [9:0] sy);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {4'b0, sy, sx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_sample(sx, sy);
        @(negedge i_clk);
    endtask

    // stop sending and wait until every predicted event is back
    task drain();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task write_reg(input t_cfg_idx idx, input int val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task apply_config(input int cx, input int cy, input int bdz, input int ddz,
                      input int ix, input int iy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_BASE_DZ, bdz);
        write_reg(CFG_DIAG_DZ, ddz);
        write_reg(CFG_INVERT_X, ix);
        write_reg(CFG_INVERT_Y, iy);
        write_reg(CFG_MODE_ENABLE, 1);
    endtask

    // mostly near the center, around the deadzone edges; some full range
    function logic [9:0] pick_axis(logic [9:0] center);
        int v, span;
        case ($urandom_range(0, 3))
            0: return 10'($urandom_range(0, 1023));
            1: span = int'(sb.base_dz) + 2;
            2: span = int'(sb.diag_dz) + 4;
            default: span = 2 * int'(sb.diag_dz) + int'(sb.base_dz) + 50;
        endcase
        if ($urandom_range(0, 1) && span > 6)
            v = int'(sb.diag_dz) - 3 + $urandom_range(0, 6);   // hug the diagonal bound
        else
            v = $urandom_range(0, span);
        v = $urandom_range(0, 1) ? int'(center) + v : int'(center) - v;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[9:0];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [9:0] dir_x[$];
        logic [9:0] dir_y[$];
        int         sent;

        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed samples at the reset register values
        dir_x = '{783, 1023,   0, 783,  783, 533, 583, 1003, 1003, 883, 882,
                  783, 1023,    0, 1023,   0, 783};
        dir_y = '{748,  748, 748,   0, 1023, 998, 1008, 1008, 448, 448, 448,
                  650, 1023,    0,    0, 1023, 748};
        foreach (dir_x[i]) send_sample(dir_x[i], dir_y[i]);
        drain();

        sent = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_config(783, 748, 100, 200, 0, 1);
                1: apply_config(512, 512, 0, 0, 1, 0);          // no deadzones
                2: apply_config(0, 1023, 100, 200, 1, 1);       // centers at the rails
                3: begin
                    // samples are dropped while disabled
                    write_reg(CFG_MODE_ENABLE, 0);
                    repeat (12) send_sample(10'($urandom_range(0, 1023)),
                                            10'($urandom_range(0, 1023)));
                    drain();
                    apply_config(1023, 0, 1023, 2047, 0, 0);    // widest deadzones
                end
                4: apply_config(512, 512, 30, 60, 0, 1);
                default: apply_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                                      $urandom_range(0, 300), $urandom_range(0, 600),
                                      $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
                if ($urandom_range(0, 4) == 0)
                    send_sample(10'($urandom_range(0, 1023)),
                                10'($urandom_range(0, 1023)));
                else
                    send_sample(pick_axis(sb.cx), pick_axis(sb.cy));
                sent++;
                // hold off until the event queue is empty now and then
                if (sent % 60 == 0) drain();
            end
            drain();
            no_idle = 1'b0;
        end

        drain();
        if (sb.errors == 0)
            $display("[joystick_to_direction_keys_top] OK");
        else
            $display("[joystick_to_direction_keys_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/jtdk_pkg.sv
src/jtdk_front.sv
src/jtdk_queue.sv
src/jtdk_back.sv
src/joystick_to_direction_keys_top.sv
tb/tb_top.sv
